[hdl/crlp_pkg.sv]
package crlp_pkg;

  localparam int PIX_W      = 32;
  localparam int CNT_W      = 13;
  localparam int COORD_W    = 16;
  // signed compare width for coordinates against the canvas bounds
  localparam int CRD_W      = 17;
  localparam int CFG_W      = 7;
  localparam int CMD_W      = 3;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 48;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam logic [CFG_W-1:0] CANVAS_RST = 7'd64;
  localparam logic [CNT_W-1:0] CNT_MAX    = 13'h1fff;

  // paddr[2] selects the register
  localparam logic REG_CANVAS_W = 1'b0;
  localparam logic REG_CANVAS_H = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET     = 3'd0,
    CMD_LINE    = 3'd1,
    CMD_FILL    = 3'd2,
    CMD_OUTLINE = 3'd3,
    CMD_READ    = 3'd4
  } cmd_t;

endpackage

[hdl/crlp_fb.sv]
module crlp_fb import crlp_pkg::*; #(
  parameter int DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [PIX_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/clipped_rect_line_painter_core.sv]
// Channel   Dir  Handshake                 Payload
// s_*       in   s_tvalid / s_tready       s_tdata: x_a, y_a, x_b, y_b, color; s_tuser: command
// m_*       out  m_tvalid / m_tready       m_tdata: read_value, pixels_written, line_skipped
// apb       in   psel & penable & pwrite   canvas_width at 0x0, canvas_height at 0x4
//
// A drawing command passes ST_SETUP for each box (each side of an outline) and ST_PAINT for
// its visible pixels, one per cycle, since the frame memory takes one write per cycle, then
// ST_DONE; a read passes ST_RDREQ and ST_RDWAIT, skipping ST_RDWAIT outside the canvas.
// Diagonal lines and unused codes go from the accept straight to ST_DONE.
// After reset a clearing pass writes zero to all MAX_WIDTH*MAX_HEIGHT words, one per cycle,
// with s_tready low; configuration writes are taken during the pass.
// The result sits in an output register, so the next command is taken while it waits;
// a finished command holds until that register is free.
module clipped_rect_line_painter_core import crlp_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [15:0] x_a, [31:16] y_a, [47:32] x_b, [63:48] y_b, [95:64] color
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // [2:0] command
  input  logic [CMD_W-1:0]      s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [31:0] read_value, [44:32] pixels_written, [45] line_skipped, [47:46] zero
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_SETUP  = 7'b0000100,
    ST_PAINT  = 7'b0001000,
    ST_RDREQ  = 7'b0010000,
    ST_RDWAIT = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0] canvas_w, canvas_h;

  cmd_t                      cmd;
  logic signed [COORD_W-1:0] xlo, xhi, ylo, yhi;
  logic [PIX_W-1:0]          color;
  logic [1:0]                box, last_box;
  logic [XW-1:0]             cx, xl_r, xh_r;
  logic [YW-1:0]             cy, yh_r;
  logic [AW-1:0]             addr, row_addr;
  logic [PIX_W-1:0]          res_rd;
  logic [CNT_W-1:0]          res_cnt;
  logic                      res_skip;

  logic                      cfg_wr;
  logic                      accept;
  logic signed [COORD_W-1:0] in_xa, in_ya, in_xb, in_yb;
  logic signed [COORD_W-1:0] bx0, bx1, by0, by1;
  logic signed [CRD_W-1:0]   vis_w_m1, vis_h_m1;
  logic signed [CRD_W-1:0]   bx0_e, bx1_e, by0_e, by1_e;
  logic signed [CRD_W-1:0]   xl_c, xh_c, yl_c, yh_c;
  logic signed [CRD_W-1:0]   rx_e, ry_e;
  logic                      box_empty, rd_inside;
  logic                      out_load;

  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_raddr;
  logic [PIX_W-1:0]          mem_wdata, mem_rdata;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_w <= CANVAS_RST;
      canvas_h <= CANVAS_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_CANVAS_W) begin
        canvas_w <= pwdata[CFG_W-1:0];
      end else begin
        canvas_h <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CANVAS_W) begin
      prdata[CFG_W-1:0] = canvas_w;
    end else begin
      prdata[CFG_W-1:0] = canvas_h;
    end
  end

  // visible extent minus one; negative when the canvas is empty
  assign vis_w_m1 = ((CRD_W'(canvas_w) > CRD_W'(MAX_WIDTH)) ? CRD_W'(MAX_WIDTH)
                                                            : CRD_W'(canvas_w)) - CRD_W'(1);
  assign vis_h_m1 = ((CRD_W'(canvas_h) > CRD_W'(MAX_HEIGHT)) ? CRD_W'(MAX_HEIGHT)
                                                             : CRD_W'(canvas_h)) - CRD_W'(1);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign in_xa    = s_tdata[15:0];
  assign in_ya    = s_tdata[31:16];
  assign in_xb    = s_tdata[47:32];
  assign in_yb    = s_tdata[63:48];

  // current box: the four sides of an outline, else the whole ordered box
  always_comb begin
    bx0 = xlo;
    bx1 = xhi;
    by0 = ylo;
    by1 = yhi;
    if (cmd == CMD_OUTLINE) begin
      unique case (box)
        2'd0: by1 = ylo;
        2'd1: by0 = yhi;
        2'd2: bx1 = xlo;
        default: bx0 = xhi;
      endcase
    end
  end

  assign bx0_e = CRD_W'(bx0);
  assign bx1_e = CRD_W'(bx1);
  assign by0_e = CRD_W'(by0);
  assign by1_e = CRD_W'(by1);
  assign xl_c  = bx0_e[CRD_W-1] ? '0 : bx0_e;
  assign yl_c  = by0_e[CRD_W-1] ? '0 : by0_e;
  assign xh_c  = (bx1_e < vis_w_m1) ? bx1_e : vis_w_m1;
  assign yh_c  = (by1_e < vis_h_m1) ? by1_e : vis_h_m1;
  assign box_empty = (xl_c > xh_c) || (yl_c > yh_c);

  assign rx_e = CRD_W'(xlo);
  assign ry_e = CRD_W'(ylo);
  assign rd_inside = !rx_e[CRD_W-1] && (rx_e <= vis_w_m1) &&
                     !ry_e[CRD_W-1] && (ry_e <= vis_h_m1);

  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (s_tuser)
            CMD_SET, CMD_FILL, CMD_OUTLINE: state_next = ST_SETUP;
            CMD_LINE: begin
              if (in_xa != in_xb && in_ya != in_yb) begin
                state_next = ST_DONE;
              end else begin
                state_next = ST_SETUP;
              end
            end
            CMD_READ: state_next = ST_RDREQ;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_SETUP: begin
        if (!box_empty) begin
          state_next = ST_PAINT;
        end else if (box == last_box) begin
          state_next = ST_DONE;
        end
      end
      ST_PAINT: begin
        if (cx == xh_r && cy == yh_r) begin
          state_next = (box == last_box) ? ST_DONE : ST_SETUP;
        end
      end
      ST_RDREQ:  state_next = rd_inside ? ST_RDWAIT : ST_DONE;
      ST_RDWAIT: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      addr  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: addr <= addr + AW'(1);
        ST_SETUP: begin
          if (!box_empty) begin
            addr     <= AW'(yl_c[YW-1:0]) * AW'(MAX_WIDTH) + AW'(xl_c[XW-1:0]);
            row_addr <= AW'(yl_c[YW-1:0]) * AW'(MAX_WIDTH) + AW'(xl_c[XW-1:0]);
          end
        end
        ST_PAINT: begin
          if (cx != xh_r) begin
            addr <= addr + AW'(1);
          end else begin
            // advance to the start of the next row
            addr     <= row_addr + AW'(MAX_WIDTH);
            row_addr <= row_addr + AW'(MAX_WIDTH);
          end
        end
        default: ;
      endcase
    end
  end

  // command registers and result accumulation
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd      <= cmd_t'(s_tuser);
      color    <= s_tdata[95:64];
      box      <= 2'd0;
      last_box <= (s_tuser == CMD_OUTLINE) ? 2'd3 : 2'd0;
      res_rd   <= '0;
      res_cnt  <= '0;
      res_skip <= (s_tuser == CMD_LINE) && (in_xa != in_xb) && (in_ya != in_yb);
      if (s_tuser == CMD_SET || s_tuser == CMD_READ) begin
        xlo <= in_xa;
        xhi <= in_xa;
        ylo <= in_ya;
        yhi <= in_ya;
      end else begin
        xlo <= (in_xa < in_xb) ? in_xa : in_xb;
        xhi <= (in_xa < in_xb) ? in_xb : in_xa;
        ylo <= (in_ya < in_yb) ? in_ya : in_yb;
        yhi <= (in_ya < in_yb) ? in_yb : in_ya;
      end
    end else begin
      unique case (state)
        ST_SETUP: begin
          if (box_empty) begin
            if (box != last_box) begin
              box <= box + 2'd1;
            end
          end else begin
            cx   <= xl_c[XW-1:0];
            cy   <= yl_c[YW-1:0];
            xl_r <= xl_c[XW-1:0];
            xh_r <= xh_c[XW-1:0];
            yh_r <= yh_c[YW-1:0];
          end
        end
        ST_PAINT: begin
          if (res_cnt != CNT_MAX) begin
            res_cnt <= res_cnt + CNT_W'(1);
          end
          if (cx != xh_r) begin
            cx <= cx + XW'(1);
          end else if (cy != yh_r) begin
            cx <= xl_r;
            cy <= cy + YW'(1);
          end else if (box != last_box) begin
            box <= box + 2'd1;
          end
        end
        ST_RDWAIT: res_rd <= mem_rdata;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, res_skip, res_cnt, res_rd};
    end
  end

  assign mem_we    = (state == ST_CLEAR) || (state == ST_PAINT);
  assign mem_wdata = (state == ST_CLEAR) ? '0 : color;
  assign mem_re    = (state == ST_RDREQ) && rd_inside;
  assign mem_raddr = AW'(ry_e[YW-1:0]) * AW'(MAX_WIDTH) + AW'(rx_e[XW-1:0]);

  crlp_fb #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_fb (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[hdl/crlp_checker.sv]
module crlp_checker import crlp_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  logic       in_xfer, out_xfer;
  logic [1:0] pend;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  // transactions taken in but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (in_xfer && !out_xfer) begin
      pend <= pend + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      pend <= pend - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or dropped while stalled");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend != 2'd3)
    else $error("more than two commands in flight");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pend != 2'd0)
    else $error("result without a command");

  a_clear_pass: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !s_tready)
    else $error("command taken during the clearing pass");

  a_skip_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[45] |-> m_tdata[44:0] == '0)
    else $error("skipped line reports pixels or data");

endmodule

bind clipped_rect_line_painter_core crlp_checker u_crlp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import crlp_pkg::*;

  localparam logic [CMD_W-1:0] CMD_RSVD_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI  = 3'd7;
  localparam int STALL_LIMIT = 20000;
  localparam int N_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 206;

  typedef struct packed {
    logic [CMD_W-1:0]          op;
    logic signed [COORD_W-1:0] xa;
    logic signed [COORD_W-1:0] ya;
    logic signed [COORD_W-1:0] xb;
    logic signed [COORD_W-1:0] yb;
    logic [PIX_W-1:0]          color;
  } draw_cmd_t;

  typedef struct packed {
    logic [PIX_W-1:0] rd;
    logic [CNT_W-1:0] count;
    logic             skipped;
  } draw_res_t;

  typedef struct {
    draw_cmd_t cmd;
    bit        typed;
    draw_res_t res;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_AW-1:0]     paddr = '0;
  logic [APB_DW-1:0]     pwdata = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // [15:0] x_a, [31:16] y_a, [47:32] x_b, [63:48] y_b, [95:64] color
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // [2:0] command
  logic [CMD_W-1:0]      s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [31:0] read_value, [44:32] pixels_written, [45] line_skipped, [47:46] zero
  logic [OUT_DATA_W-1:0] m_tdata;

  logic [PIX_W-1:0] frame_mem [MAX_WIDTH_DEF*MAX_HEIGHT_DEF];
  logic [CFG_W-1:0] canvas_w = CANVAS_RST;
  logic [CFG_W-1:0] canvas_h = CANVAS_RST;
  draw_res_t        pending_results [$];
  int               send_idle_pct = 0;
  int               recv_stall_pct = 0;
  int               errors = 0;
  int               stall_cycles = 0;

  stim_row_t directed_rows [27] = '{
    '{'{CMD_READ, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0}, 1'b1, '{32'h0, 13'd0, 1'b0}},
    '{'{CMD_SET, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'hFFFFFFFF}, 1'b1, '{32'h0, 13'd1, 1'b0}},
    '{'{CMD_READ, 16'sd0, 16'sd0, 16'sd9, 16'sd9, 32'h0}, 1'b1,
      '{32'hFFFFFFFF, 13'd0, 1'b0}},
    '{'{CMD_SET, 16'sd63, 16'sd63, 16'sd0, 16'sd0, 32'h12345678}, 1'b1,
      '{32'h0, 13'd1, 1'b0}},
    '{'{CMD_READ, 16'sd63, 16'sd63, 16'sd0, 16'sd0, 32'h0}, 1'b1,
      '{32'h12345678, 13'd0, 1'b0}},
    '{'{CMD_SET, 16'sd64, 16'sd0, 16'sd0, 16'sd0, 32'hA5A5A5A5}, 1'b1, '{32'h0, 13'd0, 1'b0}},
    '{'{CMD_SET, 16'sd0, 16'sd64, 16'sd0, 16'sd0, 32'hA5A5A5A5}, 1'b1, '{32'h0, 13'd0, 1'b0}},
    '{'{CMD_SET, -16'sd1, 16'sd5, 16'sd0, 16'sd0, 32'hA5A5A5A5}, 1'b1, '{32'h0, 13'd0, 1'b0}},
    '{'{CMD_SET, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 32'h5A5A5A5A}, 1'b1,
      '{32'h0, 13'd0, 1'b0}},
    '{'{CMD_SET, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'h5A5A5A5A}, 1'b1,
      '{32'h0, 13'd0, 1'b0}},
    '{'{CMD_READ, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 32'h0}, 1'b1, '{32'h0, 13'd0, 1'b0}},
    '{'{CMD_READ, 16'sd0, 16'sd64, 16'sd0, 16'sd0, 32'h0}, 1'b1, '{32'h0, 13'd0, 1'b0}},
    '{'{CMD_LINE, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 32'hDEADBEEF}, 1'b1, '{32'h0, 13'd0, 1'b1}},
    '{'{CMD_LINE, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 32'h0000BEEF}, 1'b1, '{32'h0, 13'd1, 1'b0}},
    '{'{CMD_LINE, 16'sh7FFF, 16'sd10, 16'sh8000, 16'sd10, 32'h00C0FFEE}, 1'b1,
      '{32'h0, 13'd64, 1'b0}},
    '{'{CMD_LINE, 16'sd20, 16'sd40, 16'sd20, 16'sd3, 32'h13579BDF}, 1'b1,
      '{32'h0, 13'd38, 1'b0}},
    '{'{CMD_READ, 16'sd20, 16'sd3, 16'sd0, 16'sd0, 32'h0}, 1'b0, '0},
    '{'{CMD_FILL, 16'sd10, 16'sd12, 16'sd3, 16'sd7, 32'h2468ACE0}, 1'b0, '0},
    '{'{CMD_OUTLINE, 16'sd2, 16'sd2, 16'sd5, 16'sd4, 32'h0F0F0F0F}, 1'b0, '0},
    '{'{CMD_OUTLINE, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 32'hF0F0F0F0}, 1'b1,
      '{32'h0, 13'd4, 1'b0}},
    '{'{CMD_OUTLINE, -16'sd5, 16'sd60, 16'sd70, 16'sd63, 32'h33CC33CC}, 1'b0, '0},
    '{'{CMD_READ, 16'sd30, 16'sd63, 16'sd0, 16'sd0, 32'h0}, 1'b0, '0},
    '{'{CMD_FILL, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 32'h5A5A5A5A}, 1'b1,
      '{32'h0, 13'd4096, 1'b0}},
    '{'{CMD_READ, 16'sd63, 16'sd0, 16'sd0, 16'sd0, 32'h0}, 1'b1,
      '{32'h5A5A5A5A, 13'd0, 1'b0}},
    '{'{CMD_RSVD_LO, 16'sd1, 16'sd1, 16'sd2, 16'sd2, 32'hFFFFFFFF}, 1'b1,
      '{32'h0, 13'd0, 1'b0}},
    '{'{CMD_RSVD_MID, 16'sd1, 16'sd1, 16'sd3, 16'sd1, 32'hFFFFFFFF}, 1'b1,
      '{32'h0, 13'd0, 1'b0}},
    '{'{CMD_RSVD_HI, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'hFFFFFFFF}, 1'b1,
      '{32'h0, 13'd0, 1'b0}}
  };

  clipped_rect_line_painter_core dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int visible_extent(logic [CFG_W-1:0] reg_val, int cap);
    return (int'(reg_val) > cap) ? cap : int'(reg_val);
  endfunction

  // Paint the ordered box [x0..x1] x [y0..y1] after clipping; return the pixel count.
  function automatic int unsigned paint_clipped(int x0, int x1, int y0, int y1,
                                                logic [PIX_W-1:0] color);
    int xl, xh, yl, yh;
    int unsigned n;
    xl = (x0 < 0) ? 0 : x0;
    yl = (y0 < 0) ? 0 : y0;
    xh = visible_extent(canvas_w, MAX_WIDTH_DEF) - 1;
    yh = visible_extent(canvas_h, MAX_HEIGHT_DEF) - 1;
    if (x1 < xh) xh = x1;
    if (y1 < yh) yh = y1;
    n = 0;
    for (int y = yl; y <= yh; y++)
      for (int x = xl; x <= xh; x++) begin
        frame_mem[y*MAX_WIDTH_DEF + x] = color;
        n++;
      end
    return n;
  endfunction

  function automatic draw_res_t predict_draw(draw_cmd_t c);
    int xa, ya, xb, yb, xlo, xhi, ylo, yhi;
    int unsigned n;
    draw_res_t r;
    xa = int'($signed(c.xa));
    ya = int'($signed(c.ya));
    xb = int'($signed(c.xb));
    yb = int'($signed(c.yb));
    xlo = (xa < xb) ? xa : xb;
    xhi = (xa < xb) ? xb : xa;
    ylo = (ya < yb) ? ya : yb;
    yhi = (ya < yb) ? yb : ya;
    r = '0;
    n = 0;
    case (c.op)
      CMD_SET: n = paint_clipped(xa, xa, ya, ya, c.color);
      CMD_LINE: begin
        if (xa == xb || ya == yb) n = paint_clipped(xlo, xhi, ylo, yhi, c.color);
        else r.skipped = 1'b1;
      end
      CMD_FILL: n = paint_clipped(xlo, xhi, ylo, yhi, c.color);
      CMD_OUTLINE: begin
        // corners are counted once per side
        n = paint_clipped(xlo, xhi, ylo, ylo, c.color);
        n += paint_clipped(xlo, xhi, yhi, yhi, c.color);
        n += paint_clipped(xlo, xlo, ylo, yhi, c.color);
        n += paint_clipped(xhi, xhi, ylo, yhi, c.color);
      end
      CMD_READ: begin
        if (xa >= 0 && xa < visible_extent(canvas_w, MAX_WIDTH_DEF) &&
            ya >= 0 && ya < visible_extent(canvas_h, MAX_HEIGHT_DEF))
          r.rd = frame_mem[ya*MAX_WIDTH_DEF + xa];
      end
      default: ;
    endcase
    if (n > 32'(CNT_MAX)) n = 32'(CNT_MAX);
    r.count = CNT_W'(n);
    return r;
  endfunction

  // Mostly near the canvas, sometimes anywhere, now and then the extremes.
  function automatic logic signed [COORD_W-1:0] near_coord();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 85) return COORD_W'(int'($urandom_range(0, 75)) - 6);
    if (roll < 95) return COORD_W'($urandom);
    return roll[0] ? 16'sh7FFF : 16'sh8000;
  endfunction

  // Keep most boxes small so the run stays short.
  function automatic logic signed [COORD_W-1:0] partner_coord(logic signed [COORD_W-1:0] a);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return COORD_W'(int'(a) + int'($urandom_range(0, 24)) - 12);
    if (roll < 90) return near_coord();
    return COORD_W'($urandom);
  endfunction

  function automatic draw_cmd_t random_command();
    draw_cmd_t c;
    int roll;
    roll = $urandom_range(0, 99);
    c.xa = near_coord();
    c.ya = near_coord();
    c.xb = partner_coord(c.xa);
    c.yb = partner_coord(c.ya);
    c.color = $urandom;
    if (roll < 14) c.op = CMD_SET;
    else if (roll < 34) begin
      c.op = CMD_LINE;
      // keep most lines axis aligned
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 1) == 0) c.xb = c.xa;
        else c.yb = c.ya;
      end
    end
    else if (roll < 49) c.op = CMD_FILL;
    else if (roll < 64) c.op = CMD_OUTLINE;
    else if (roll < 95) c.op = CMD_READ;
    else c.op = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    return c;
  endfunction

  task automatic send_command(input draw_cmd_t c, input bit typed, input draw_res_t typed_res);
    draw_res_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.op;
    s_tdata  <= {c.color, c.yb, c.xb, c.ya, c.xa};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = predict_draw(c);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic write_canvas_reg(input logic reg_sel, input logic [CFG_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= APB_DW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (reg_sel == REG_CANVAS_W) canvas_w = val;
    else canvas_h = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    draw_res_t want;
    if (m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no command outstanding: %h", m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[31:0] !== want.rd) begin
          $error("read_value: expected %h, got %h", want.rd, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[44:32] !== want.count) begin
          $error("pixels_written: expected %0d, got %0d", want.count, m_tdata[44:32]);
          errors++;
        end
        if (m_tdata[45] !== want.skipped) begin
          $error("line_skipped: expected %b, got %b", want.skipped, m_tdata[45]);
          errors++;
        end
      end
    end
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // The clearing pass after reset counts against this limit too.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
      stall_cycles <= 0;
    else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL clipped_rect_line_painter_core");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    logic [CFG_W-1:0] w, h;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].res);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin w = 7'd127; h = 7'd127; end
        1: begin w = 7'd1;   h = 7'd1;   end
        2: begin w = 7'd0;   h = 7'd40;  end
        3: begin w = 7'd50;  h = 7'd0;   end
        4: begin w = 7'd17;  h = 7'd9;   end
        5: begin w = 7'd64;  h = 7'd1;   end
        6: begin w = 7'd1;   h = 7'd64;  end
        default: begin
          w = CFG_W'($urandom_range(0, 127));
          h = CFG_W'($urandom_range(0, 127));
        end
      endcase
      write_canvas_reg(REG_CANVAS_W, w);
      write_canvas_reg(REG_CANVAS_H, h);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        send_command(random_command(), 1'b0, '0);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("PASS clipped_rect_line_painter_core");
    else $display("FAIL clipped_rect_line_painter_core");
    $finish;
  end

endmodule

[filelist.f]
hdl/crlp_pkg.sv
hdl/crlp_fb.sv
hdl/clipped_rect_line_painter_core.sv
hdl/crlp_checker.sv
tb/testbench.sv
